[sv/atl_pkg.sv]
// Shared types, constants and character helpers for the assembly token lexer.
// Used by the sequencer top level, the shared adder and the port checker.
package atl_pkg;

	localparam int MAX_LABEL_LEN = 32;
	localparam int LEN_W = $clog2(MAX_LABEL_LEN);
	localparam int CFG_IDX_W = 2;
	localparam int ALU_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_NARROW = CFG_IDX_W'(1);

	localparam logic [15:0] MAX_WIDE_RST = 16'hFFFF;
	localparam logic [15:0] MAX_NARROW_RST = 16'h00FF;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE = 8'h31;
	localparam logic [7:0] CH_X = 8'h78;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_US = 8'h5F;

	typedef enum logic [2:0] {
		K_COLON,
		K_COMMA,
		K_LPAREN,
		K_RPAREN,
		K_IDCHAR,
		K_NARROW,
		K_WIDE,
		K_ERROR
	} token_kind_t;

	typedef enum logic [1:0] {
		E_NONE,
		E_LABEL_LONG,
		E_NUM_BIG,
		E_UNKNOWN
	} error_code_t;

	typedef enum logic [2:0] {
		M_IDLE,
		M_IDENT,
		M_ZERO,
		M_DEC,
		M_HEX,
		M_BIN,
		M_HALT
	} scan_mode_t;

	typedef enum logic [3:0] {
		S_WAIT,
		S_DISPATCH,
		S_ID_RD,
		S_ID_OUT,
		S_LONG_OUT,
		S_CMP_WIDE,
		S_CMP_NARROW,
		S_NUM_OUT,
		S_MAC1,
		S_MAC2,
		S_CHAR,
		S_END
	} seq_state_t;

	typedef struct packed {
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
		logic             sub;
	} alu_req_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= 8'h39;
	endfunction

	function automatic logic is_hex_letter(input logic [7:0] c);
		return c >= 8'h61 && c <= 8'h66;
	endfunction

endpackage

[sv/atl_alu.sv]
// Shared add/subtract unit of the lexer sequencer.
// Serves number accumulation and both limit compares; depends on atl_pkg.
module atl_alu import atl_pkg::*; (
	input  alu_req_t         req,
	output logic [ALU_W:0]   res
);

	always_comb begin
		if (req.sub) begin
			res = {1'b0, req.a} - {1'b0, req.b};
		end else begin
			res = {1'b0, req.a} + {1'b0, req.b};
		end
	end

endmodule

[sv/asm_token_lexer_unit.sv]
// Top level of the assembly token lexer: sequencer, label store, limit registers.
// Depends on atl_pkg and atl_alu.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in      | sink      | in_valid / in_stall   | char_byte, end_of_text
//  out     | source    | out_valid / out_stall | token_kind, number_value, id_char,
//          |           |                      | token_last, error_code
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One request at a time: the input stalls until the sequencer is back in S_WAIT. A decimal digit
// passes through the shared adder twice, a hex or binary digit once (a decimal digit only once if the
// value has already overflowed), and a number end takes the two limit compares.
// Each buffered label character is read on the label store's registered read port.
// Reset clears control state and loads the limits with their reset values; the label store needs no clearing pass.
// A stalled result holds; the sequencer waits on a full output register.
module asm_token_lexer_unit import atl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_text,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           token_kind,
	output logic [15:0]          number_value,
	output logic [7:0]           id_char,
	output logic                 token_last,
	output logic [1:0]           error_code,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LABEL_LEN - 1);

	seq_state_t       state_q, state_d;
	scan_mode_t       mode_q;
	logic [LEN_W-1:0] len_q, idx_q;
	logic [16:0]      acc_q;
	logic             ovf_q;
	logic [7:0]       c_q;
	logic             eot_q;
	logic             flush_end_q;
	logic             after_char_q;
	logic             too_big_q;
	logic             wide_q;
	logic [19:0]      tmp_q;
	logic [15:0]      max_wide_q, max_narrow_q;

	logic [7:0]       mem [MAX_LABEL_LEN];
	logic [7:0]       rd_q;

	logic             out_valid_q;
	token_kind_t      kind_q;
	logic [15:0]      value_q;
	logic [7:0]       char_q;
	logic             last_q;
	error_code_t      err_q;

	alu_req_t         alu_req;
	logic [ALU_W:0]   alu_res;

	logic             out_free;
	logic             c_letter, c_digit, c_alnum, c_sep, c_emits, c_mode_digit;
	logic             mode_num, end_cond, id_last;
	logic [3:0]       dval;

	logic             emit;
	token_kind_t      e_kind;
	logic [15:0]      e_value;
	logic [7:0]       e_char;
	logic             e_last;
	error_code_t      e_err;

	logic             mem_we;
	logic [LEN_W-1:0] mem_waddr;

	atl_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	assign in_stall = (state_q != S_WAIT);
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	assign c_letter = is_letter(c_q);
	assign c_digit = is_digit(c_q);
	assign c_alnum = c_letter || c_digit;
	assign c_sep = (c_q == CH_SPACE) || (c_q == CH_TAB) || (c_q == CH_LF);
	assign c_emits = !c_alnum && !c_sep;
	assign mode_num = (mode_q == M_ZERO) || (mode_q == M_DEC) || (mode_q == M_HEX)
		|| (mode_q == M_BIN);
	assign end_cond = eot_q || (c_q == CH_NUL);
	assign id_last = (idx_q + LEN_W'(1)) == len_q;
	assign dval = c_digit ? c_q[3:0] : c_q[3:0] + 4'd9;

	always_comb begin
		case (mode_q)
			M_BIN:   c_mode_digit = (c_q == CH_ZERO) || (c_q == CH_ONE);
			M_HEX:   c_mode_digit = c_digit || is_hex_letter(c_q);
			default: c_mode_digit = c_digit;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_WAIT: begin
				if (in_valid) state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				if (mode_q == M_HALT || c_q == CH_NUL) begin
					state_d = S_END;
				end else begin
					case (mode_q)
						M_IDENT: begin
							if (!c_alnum) state_d = S_ID_RD;
							else if (len_q >= LEN_LIMIT) state_d = S_LONG_OUT;
							else state_d = S_END;
						end
						M_ZERO: begin
							if (c_q == CH_X || c_q == CH_B) state_d = S_END;
							else if (c_digit) state_d = S_MAC1;
							else state_d = S_CMP_WIDE;
						end
						M_DEC, M_HEX, M_BIN: begin
							state_d = c_mode_digit ? S_MAC1 : S_CMP_WIDE;
						end
						default: state_d = S_CHAR;
					endcase
				end
			end
			S_ID_RD: state_d = S_ID_OUT;
			S_ID_OUT: begin
				if (out_free) begin
					if (!id_last) state_d = S_ID_RD;
					else state_d = after_char_q ? S_CHAR : S_END;
				end
			end
			S_LONG_OUT: begin
				if (out_free) state_d = S_END;
			end
			S_CMP_WIDE:   state_d = S_CMP_NARROW;
			S_CMP_NARROW: state_d = S_NUM_OUT;
			S_NUM_OUT: begin
				if (out_free) state_d = (after_char_q && !too_big_q) ? S_CHAR : S_END;
			end
			S_MAC1: state_d = ovf_q ? S_END : S_MAC2;
			S_MAC2: state_d = S_END;
			S_CHAR: begin
				if (!c_emits || out_free) state_d = S_END;
			end
			S_END: begin
				if (end_cond && !flush_end_q && mode_q == M_IDENT) state_d = S_ID_RD;
				else if (end_cond && !flush_end_q && mode_num) state_d = S_CMP_WIDE;
				else state_d = S_WAIT;
			end
			default: state_d = S_WAIT;
		endcase
	end

	// result, adder and store controls
	always_comb begin
		emit = 1'b0;
		e_kind = K_ERROR;
		e_value = '0;
		e_char = '0;
		e_last = 1'b1;
		e_err = E_NONE;
		mem_we = 1'b0;
		mem_waddr = len_q;
		alu_req = '0;
		case (state_q)
			S_DISPATCH: begin
				mem_we = (mode_q == M_IDENT) && (c_q != CH_NUL) && c_alnum
					&& (len_q < LEN_LIMIT);
			end
			S_ID_OUT: begin
				emit = out_free;
				e_kind = K_IDCHAR;
				e_char = rd_q;
				e_last = id_last;
			end
			S_LONG_OUT: begin
				emit = out_free;
				e_err = E_LABEL_LONG;
			end
			S_CMP_WIDE: begin
				alu_req.a = ALU_W'(max_wide_q);
				alu_req.b = ALU_W'(acc_q);
				alu_req.sub = 1'b1;
			end
			S_CMP_NARROW: begin
				alu_req.a = ALU_W'(max_narrow_q);
				alu_req.b = ALU_W'(acc_q);
				alu_req.sub = 1'b1;
			end
			S_NUM_OUT: begin
				emit = out_free;
				if (too_big_q) begin
					e_err = E_NUM_BIG;
				end else begin
					e_kind = wide_q ? K_WIDE : K_NARROW;
					e_value = acc_q[15:0];
				end
			end
			S_MAC1: begin
				alu_req.a = ALU_W'({acc_q[15:0], 3'b000});
				alu_req.b = ALU_W'({acc_q[15:0], 1'b0});
			end
			S_MAC2: begin
				alu_req.a = ALU_W'(tmp_q);
				alu_req.b = ALU_W'(dval);
			end
			S_CHAR: begin
				emit = c_emits && out_free;
				mem_we = c_letter;
				mem_waddr = '0;
				case (c_q)
					CH_COLON:  e_kind = K_COLON;
					CH_COMMA:  e_kind = K_COMMA;
					CH_LPAREN: e_kind = K_LPAREN;
					CH_RPAREN: e_kind = K_RPAREN;
					default:   e_err = E_UNKNOWN;
				endcase
			end
			default: ;
		endcase
	end

	// label store
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= c_q;
		rd_q <= mem[idx_q];
	end

	// sequencer data path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
			mode_q <= M_IDLE;
			len_q <= '0;
			idx_q <= '0;
			acc_q <= '0;
			ovf_q <= 1'b0;
			flush_end_q <= 1'b0;
			after_char_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_WAIT: begin
					flush_end_q <= 1'b0;
				end
				S_DISPATCH: begin
					after_char_q <= 1'b1;
					idx_q <= '0;
					if (mode_q != M_HALT && c_q != CH_NUL) begin
						case (mode_q)
							M_IDENT: begin
								if (c_alnum && len_q < LEN_LIMIT) len_q <= len_q + LEN_W'(1);
							end
							M_ZERO: begin
								if (c_q == CH_X) mode_q <= M_HEX;
								else if (c_q == CH_B) mode_q <= M_BIN;
								else if (c_digit) mode_q <= M_DEC;
							end
							default: ;
						endcase
					end
				end
				S_ID_OUT: begin
					if (out_free) begin
						if (id_last) begin
							len_q <= '0;
							mode_q <= M_IDLE;
						end else begin
							idx_q <= idx_q + LEN_W'(1);
						end
					end
				end
				S_LONG_OUT: begin
					if (out_free) begin
						len_q <= '0;
						mode_q <= M_HALT;
					end
				end
				S_NUM_OUT: begin
					if (out_free) begin
						acc_q <= '0;
						ovf_q <= 1'b0;
						mode_q <= too_big_q ? M_HALT : M_IDLE;
					end
				end
				S_CHAR: begin
					if (c_letter) begin
						mode_q <= M_IDENT;
						len_q <= LEN_W'(1);
					end else if (c_digit) begin
						acc_q <= 17'(c_q[3:0]);
						ovf_q <= 1'b0;
						mode_q <= (c_q == CH_ZERO) ? M_ZERO : M_DEC;
					end else if (c_emits && out_free && e_err == E_UNKNOWN) begin
						mode_q <= M_HALT;
					end
				end
				S_MAC2: begin
					if (|alu_res[ALU_W:16]) begin
						ovf_q <= 1'b1;
						acc_q <= 17'h10000;
					end else begin
						acc_q <= alu_res[16:0];
					end
				end
				S_END: begin
					if (end_cond && !flush_end_q && (mode_q == M_IDENT || mode_num)) begin
						flush_end_q <= 1'b1;
						after_char_q <= 1'b0;
						idx_q <= '0;
					end else if (end_cond) begin
						mode_q <= M_IDLE;
						len_q <= '0;
						acc_q <= '0;
						ovf_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// request capture, compare flags and partial products
	always_ff @(posedge clk) begin
		if (state_q == S_WAIT && in_valid) begin
			c_q <= char_byte;
			eot_q <= end_of_text;
		end
		if (state_q == S_CMP_WIDE) too_big_q <= ovf_q || alu_res[ALU_W];
		if (state_q == S_CMP_NARROW) wide_q <= alu_res[ALU_W];
		if (state_q == S_MAC1) begin
			case (mode_q)
				M_HEX:   tmp_q <= {acc_q[15:0], 4'b0000};
				M_BIN:   tmp_q <= {3'b000, acc_q[15:0], 1'b0};
				default: tmp_q <= alu_res[19:0];
			endcase
		end
	end

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_wide_q <= MAX_WIDE_RST;
			max_narrow_q <= MAX_NARROW_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_WIDE:   max_wide_q <= cfg_data;
				REG_MAX_NARROW: max_narrow_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q <= e_kind;
			value_q <= e_value;
			char_q <= e_char;
			last_q <= e_last;
			err_q <= e_err;
		end
	end

	assign out_valid = out_valid_q;
	assign token_kind = kind_q;
	assign number_value = value_q;
	assign id_char = char_q;
	assign token_last = last_q;
	assign error_code = err_q;

endmodule

[sv/atl_checker.sv]
// Port-level checks of the assembly token lexer, bound to its top level.
// Depends on atl_pkg for token kinds and error codes.
module atl_checker import atl_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [7:0]           char_byte,
	input logic                 end_of_text,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [2:0]           token_kind,
	input logic [15:0]          number_value,
	input logic [7:0]           id_char,
	input logic                 token_last,
	input logic [1:0]           error_code,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [15:0]          cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid
			&& $stable({token_kind, number_value, id_char, token_last, error_code}))
		else $error("stalled result changed");

	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	a_error_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == K_ERROR |-> token_last && error_code != E_NONE
			&& number_value == 16'd0 && id_char == 8'd0)
		else $error("malformed error result");

	a_token_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != K_ERROR |-> error_code == E_NONE
			&& (token_kind == K_IDCHAR || (id_char == 8'd0 && token_last)))
		else $error("malformed token result");

endmodule

bind asm_token_lexer_unit atl_checker u_atl_checker (.*);

[tb/sv/atl_token_checker.sv]
// Token checker for the assembly token lexer: follows the byte, token and limit
// channels, predicts the token stream and compares it field by field.
// Depends on atl_pkg for the limit indexes, token kinds, error codes and scan modes.
module atl_token_checker import atl_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [7:0]           char_byte,
	input  logic                 end_of_text,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [2:0]           token_kind,
	input  logic [15:0]          number_value,
	input  logic [7:0]           id_char,
	input  logic                 token_last,
	input  logic [1:0]           error_code,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	output int                   token_errors,
	output int                   tokens_pending,
	output int                   live_bytes
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		token_kind_t kind;
		logic [15:0] value;
		logic [7:0]  ch;
		logic        last;
		error_code_t err;
	} lex_token_t;

	lex_token_t  expected_tokens[$];
	scan_mode_t  mode;
	logic [7:0]  label_buf [MAX_LABEL_LEN];
	int          label_len;
	logic [16:0] acc;
	logic        acc_big;
	logic [15:0] wide_limit;
	logic [15:0] narrow_limit;
	int          errors;
	int          live;

	function automatic logic word_char(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
	endfunction

	function automatic logic dec_char(logic [7:0] c);
		return c >= CH_ZERO && c <= 8'h39;
	endfunction

	function automatic int digit_of(scan_mode_t m, logic [7:0] c);
		if (m == M_BIN)
			return (c == CH_ZERO || c == CH_ONE) ? int'(c - CH_ZERO) : 16;
		if (dec_char(c))
			return int'(c - CH_ZERO);
		if (m == M_HEX && c >= 8'h61 && c <= 8'h66)
			return int'(c - 8'h61) + 10;
		return 16;
	endfunction

	task automatic put_token(token_kind_t kind, logic [15:0] value, logic [7:0] ch,
			logic last, error_code_t err);
		lex_token_t t;
		t = '{kind, value, ch, last, err};
		expected_tokens.push_back(t);
	endtask

	task automatic clear_scan();
		mode = M_IDLE;
		label_len = 0;
		acc = '0;
		acc_big = 1'b0;
	endtask

	task automatic emit_label();
		for (int i = 0; i < label_len; i++)
			put_token(K_IDCHAR, 16'd0, label_buf[i], i + 1 == label_len, E_NONE);
		label_len = 0;
		mode = M_IDLE;
	endtask

	task automatic emit_number(output logic ok);
		ok = !(acc_big || acc > {1'b0, wide_limit});
		if (!ok)
			put_token(K_ERROR, 16'd0, 8'd0, 1'b1, E_NUM_BIG);
		else if (acc <= {1'b0, narrow_limit})
			put_token(K_NARROW, acc[15:0], 8'd0, 1'b1, E_NONE);
		else
			put_token(K_WIDE, acc[15:0], 8'd0, 1'b1, E_NONE);
		acc = '0;
		acc_big = 1'b0;
		mode = ok ? M_IDLE : M_HALT;
	endtask

	task automatic add_digit(int radix, int d);
		int v;
		if (acc_big)
			return;
		v = int'(acc) * radix + d;
		if (v > 65535) begin
			acc_big = 1'b1;
			acc = 17'h10000;
		end else begin
			acc = v[16:0];
		end
	endtask

	task automatic start_byte(logic [7:0] c);
		if (word_char(c)) begin
			mode = M_IDENT;
			label_buf[0] = c;
			label_len = 1;
		end else if (dec_char(c)) begin
			acc = {9'd0, c - CH_ZERO};
			acc_big = 1'b0;
			if (c == CH_ZERO)
				mode = M_ZERO;
			else
				mode = M_DEC;
		end else begin
			case (c)
				CH_COLON: put_token(K_COLON, 16'd0, 8'd0, 1'b1, E_NONE);
				CH_COMMA: put_token(K_COMMA, 16'd0, 8'd0, 1'b1, E_NONE);
				CH_LPAREN: put_token(K_LPAREN, 16'd0, 8'd0, 1'b1, E_NONE);
				CH_RPAREN: put_token(K_RPAREN, 16'd0, 8'd0, 1'b1, E_NONE);
				CH_SPACE, CH_TAB, CH_LF: ;
				default: begin
					put_token(K_ERROR, 16'd0, 8'd0, 1'b1, E_UNKNOWN);
					mode = M_HALT;
				end
			endcase
		end
	endtask

	task automatic flush_pending();
		logic ok;
		if (mode == M_IDENT)
			emit_label();
		else if (mode inside {M_ZERO, M_DEC, M_HEX, M_BIN})
			emit_number(ok);
	endtask

	task automatic lex_byte(logic [7:0] c, logic eot);
		int   d;
		logic ok;
		live++;
		if (mode == M_HALT) begin
			if (eot || c == CH_NUL)
				clear_scan();
			return;
		end
		if (c == CH_NUL) begin
			flush_pending();
			clear_scan();
			return;
		end
		case (mode)
			M_IDENT: begin
				if (word_char(c) || dec_char(c)) begin
					if (label_len >= MAX_LABEL_LEN - 1) begin
						put_token(K_ERROR, 16'd0, 8'd0, 1'b1, E_LABEL_LONG);
						label_len = 0;
						mode = M_HALT;
					end else begin
						label_buf[label_len] = c;
						label_len++;
					end
				end else begin
					emit_label();
					start_byte(c);
				end
			end
			M_ZERO: begin
				if (c == CH_X) begin
					mode = M_HEX;
				end else if (c == CH_B) begin
					mode = M_BIN;
				end else if (dec_char(c)) begin
					mode = M_DEC;
					add_digit(10, int'(c - CH_ZERO));
				end else begin
					emit_number(ok);
					if (ok)
						start_byte(c);
				end
			end
			M_DEC, M_HEX, M_BIN: begin
				d = digit_of(mode, c);
				if (d < 16) begin
					add_digit(mode == M_HEX ? 16 : (mode == M_BIN ? 2 : 10), d);
				end else begin
					emit_number(ok);
					if (ok)
						start_byte(c);
				end
			end
			default: start_byte(c);
		endcase
		if (eot) begin
			if (mode != M_HALT)
				flush_pending();
			clear_scan();
		end
	endtask

	task automatic check_token();
		lex_token_t want;
		if (expected_tokens.size() == 0) begin
			if (errors < 10)
				$display("%t unexpected token: kind %0d value %0d char %0d last %0b code %0d",
					$realtime, token_kind, number_value, id_char, token_last, error_code);
			errors++;
			return;
		end
		want = expected_tokens.pop_front();
		if (token_kind !== want.kind || number_value !== want.value || id_char !== want.ch ||
				token_last !== want.last || error_code !== want.err) begin
			if (errors < 10) begin
				$display("%t token mismatch: expected kind %0d value %0d char %0d last %0b code %0d",
					$realtime, want.kind, want.value, want.ch, want.last, want.err);
				$display("%t                 got      kind %0d value %0d char %0d last %0b code %0d",
					$realtime, token_kind, number_value, id_char, token_last, error_code);
			end
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_tokens.delete();
			clear_scan();
			wide_limit = MAX_WIDE_RST;
			narrow_limit = MAX_NARROW_RST;
			errors = 0;
			live = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_MAX_WIDE)
					wide_limit = cfg_data;
				else if (cfg_index == REG_MAX_NARROW)
					narrow_limit = cfg_data;
			end
			if (in_valid && !in_stall)
				lex_byte(char_byte, end_of_text);
			if (out_valid && !out_stall)
				check_token();
		end
		token_errors <= errors;
		tokens_pending <= expected_tokens.size();
		live_bytes <= live;
	end

endmodule

[tb/sv/asm_token_lexer_unit_tb.sv]
// Testbench top for asm_token_lexer_unit: clock, reset, byte and limit stimulus,
// random output stalls and the verdict. Depends on atl_pkg and atl_token_checker.
module asm_token_lexer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import atl_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [7:0]           char_byte;
	logic                 end_of_text;
	logic                 out_valid;
	logic                 out_stall;
	logic [2:0]           token_kind;
	logic [15:0]          number_value;
	logic [7:0]           id_char;
	logic                 token_last;
	logic [1:0]           error_code;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0]          cfg_data;
	int                   token_errors;
	int                   tokens_pending;
	int                   live_bytes;
	bit                   feed_quiet;
	bit                   drain_quiet;

	asm_token_lexer_unit dut (.*);

	atl_token_checker checker_i (.*);

	always #5 clk = ~clk;

	function automatic logic pick_eot();
		return $urandom_range(0, 49) == 0;
	endfunction

	function automatic logic [7:0] word_byte(logic first);
		case ($urandom_range(0, first ? 2 : 3))
			0: return 8'($urandom_range(8'h61, 8'h7A));
			1: return 8'($urandom_range(8'h41, 8'h5A));
			2: return CH_US;
			default: return 8'($urandom_range(8'h30, 8'h39));
		endcase
	endfunction

	task automatic send_item(logic [7:0] c, logic eot);
		int gap;
		gap = feed_quiet ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= c;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_text(string s, logic eot_last);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], eot_last && i == s.len() - 1);
	endtask

	task automatic send_token();
		int    pick;
		int    len;
		int    v;
		string s;
		if ($urandom_range(0, 29) == 0)
			feed_quiet = !feed_quiet;
		if ($urandom_range(0, 29) == 0)
			drain_quiet = !drain_quiet;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(29, 33) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				send_item(word_byte(i == 0), pick_eot());
		end else if (pick < 50) begin
			case ($urandom_range(0, 3))
				0: v = $urandom_range(0, 9);
				1: v = $urandom_range(0, 255);
				2: v = $urandom_range(0, 65535);
				default: v = $urandom_range(0, 200000);
			endcase
			case ($urandom_range(0, 3))
				0: s = $sformatf("%0d", v);
				1: s = $sformatf("0x%0h", v);
				2: s = $sformatf("0b%0b", v);
				default: s = $sformatf("0%0d", v);
			endcase
			if ($urandom_range(0, 19) == 0)
				s = $urandom_range(0, 1) ? "0x" : "0b";
			for (int i = 0; i < s.len(); i++)
				send_item(s[i], pick_eot());
		end else if (pick < 65) begin
			case ($urandom_range(0, 3))
				0: send_item(CH_COLON, pick_eot());
				1: send_item(CH_COMMA, pick_eot());
				2: send_item(CH_LPAREN, pick_eot());
				default: send_item(CH_RPAREN, pick_eot());
			endcase
		end else if (pick < 90) begin
			case ($urandom_range(0, 2))
				0: send_item(CH_SPACE, pick_eot());
				1: send_item(CH_TAB, pick_eot());
				default: send_item(CH_LF, pick_eot());
			endcase
		end else if (pick < 94) begin
			send_item(CH_NUL, pick_eot());
		end else begin
			send_item(8'($urandom_range(0, 255)), pick_eot());
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (tokens_pending != 0);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_limits(logic [15:0] wide, logic [15:0] narrow);
		cfg_valid <= 1'b1;
		cfg_index <= REG_MAX_WIDE;
		cfg_data <= wide;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MAX_NARROW;
		cfg_data <= narrow;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_text(int target);
		int base;
		base = live_bytes;
		while (live_bytes - base < target)
			send_token();
		in_valid <= 1'b0;
	endtask

	initial begin
		int hold;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = drain_quiet ? 0 : $urandom_range(0, 15);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		#20_000_000;
		$display("asm_token_lexer_unit verification failed");
		$finish;
	end

	initial begin
		int drain_cycles;
		in_valid <= 1'b0;
		char_byte <= CH_NUL;
		end_of_text <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MAX_WIDE;
		cfg_data <= 16'd0;
		feed_quiet = 1'b0;
		drain_quiet = 1'b0;
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("a_Z9:0xa9,(0b1)", 1'b0);
		send_text("0x", 1'b1);
		send_text("0300\t#", 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(CH_NUL, 1'b0);
		in_valid <= 1'b0;
		wait_idle();

		set_limits(16'hFFFF, 16'h00FF);
		run_text(55);
		wait_idle();
		set_limits(16'd0, 16'd0);
		run_text(55);
		wait_idle();
		set_limits(16'hFFFF, 16'hFFFF);
		run_text(55);
		wait_idle();
		set_limits(16'd300, 16'd1000);
		run_text(55);
		wait_idle();
		set_limits(16'd1000, 16'd16);
		run_text(55);
		wait_idle();
		set_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
		run_text(55);

		drain_cycles = 0;
		do begin
			@(posedge clk);
			drain_cycles++;
		end while (tokens_pending != 0 && drain_cycles < 20000);
		repeat (40) @(posedge clk);
		if (token_errors == 0 && tokens_pending == 0)
			$display("asm_token_lexer_unit verification clean");
		else
			$display("asm_token_lexer_unit verification failed");
		$finish;
	end

endmodule
